// ----- src/llbc_pkg.sv -----
// shared types and constants for the leveled lru byte budget cache
// no dependencies

package llbc_pkg;

    localparam int SLOTS_DEF  = 32;
    localparam int LEVELS_DEF = 8;
    localparam logic [31:0] CAP_RESET    = 32'd16777216;
    localparam logic [31:0] THRESH_RESET = 32'd262144;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_TOUCH  = 2'd1,
        FN_DELETE = 2'd2,
        FN_QUERY  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CACHED  = 3'd1,
        ST_LARGE   = 3'd2,
        ST_NOVICT  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic        ins;      // load this cell if sel
        logic        del;      // free this cell if sel
        logic        touch;    // stamp this cell with new age if sel
        logic [31:0] size;
        logic [3:0]  level;
        logic        flush;
        logic [31:0] stamp;
    } cell_cmd_t;

endpackage

// ----- src/llbc_cell.sv -----
// one cache slot cell: holds valid, size, level, flush and recency stamp
// the chain passes the running best victim candidate cell to cell
// depends on llbc_pkg

module llbc_cell
    import llbc_pkg::*;
#(
    parameter int LW = 4,
    parameter int SW = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sel,
    input  cell_cmd_t       cmd,
    input  logic [LW-1:0]   min_level,
    // candidate arriving from the previous cell
    input  logic            in_found,
    input  logic [LW-1:0]   in_level,
    input  logic [31:0]     in_stamp,
    input  logic [SW-1:0]   in_idx,
    input  logic [SW-1:0]   my_idx,
    output logic            out_found,
    output logic [LW-1:0]   out_level,
    output logic [31:0]     out_stamp,
    output logic [SW-1:0]   out_idx,
    output logic            valid,
    output logic [31:0]     size,
    output logic            flush,
    output logic [LW-1:0]   level
);

    logic          valid_reg;
    logic [31:0]   size_reg;
    logic          flush_reg;
    logic [LW-1:0] level_reg;
    logic [31:0]   stamp_reg;
    logic          better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && cmd.ins)
        begin
            valid_reg <= 1'b1;
        end
        else if (sel && cmd.del)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.ins)
        begin
            size_reg  <= cmd.size;
            flush_reg <= cmd.flush;
            level_reg <= cmd.level[LW-1:0];
        end
        if (sel && (cmd.ins || cmd.touch))
        begin
            stamp_reg <= cmd.stamp;
        end
    end

    // higher level wins, then older stamp
    always_comb
    begin
        better = 1'b0;
        if (valid_reg && level_reg > min_level)
        begin
            if (!in_found || level_reg > in_level)
                better = 1'b1;
            else if (level_reg == in_level && stamp_reg < in_stamp)
                better = 1'b1;
        end
    end

    assign out_found = in_found || better;
    assign out_level = better ? level_reg : in_level;
    assign out_stamp = better ? stamp_reg : in_stamp;
    assign out_idx   = better ? my_idx : in_idx;
    assign valid     = valid_reg;
    assign size      = size_reg;
    assign flush     = flush_reg;
    assign level     = level_reg;

endmodule

// ----- src/leveled_lru_byte_budget_cache_unit.sv -----
// top level of the leveled lru byte budget cache: controller and cell chain
// depends on llbc_pkg and llbc_cell
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | func, slot, entry_size, prio_level, flush
//  result   | result_strobe      | is_eviction, evicted_slot, evict_flush,
//           |                    | status, available, last
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// touch, delete, query and refused inserts: the result beat is registered in
// S_EXEC and shown in S_DONE; the next command is taken back in S_IDLE
// an insert that fits: the result beat is registered in S_SEARCH instead
// each eviction goes through S_SEARCH, S_WALK while the candidate crosses the
// registered links between 8-cell segments, and S_EVICT, which gives a beat
// lru order is kept as a 32-bit recency stamp per cell, lowest is oldest
// rst_n clears valid bits, byte counters and registers; slot payloads are
// loaded on insert
// result beats cannot be stalled; busy stays high until the last beat

module leveled_lru_byte_budget_cache_unit
    import llbc_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  slot,
    input  logic [31:0] entry_size,
    input  logic [2:0]  prio_level,
    input  logic        flush_on_evict,
    output logic        result_strobe,
    output logic        is_eviction,
    output logic [4:0]  evicted_slot,
    output logic        evict_flush,
    output logic [2:0]  status,
    output logic        available,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SW   = $clog2(SLOTS);
    localparam int GRP  = 8;                          // cells per chain segment
    localparam int NSEG = (SLOTS + GRP - 1) / GRP;    // number of chain segments

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_WALK,
        S_EVICT,
        S_DONE
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [31:0]   cap_reg;
    logic [31:0]   cap_next;
    logic [31:0]   thresh_reg;
    logic [31:0]   thresh_next;
    logic [36:0]   held_full_reg;     // sum of sizes; 32 slots of 32 bits fit 37
    logic [36:0]   held_full_next;
    logic [36:0]   evb_reg [LEVELS];  // bytes held above each level
    logic [36:0]   evb_next [LEVELS];
    logic [31:0]   stamp_reg;
    logic [31:0]   stamp_next;

    func_t         f_reg;
    func_t         f_next;
    logic [4:0]    s_reg;
    logic [4:0]    s_next;
    logic [31:0]   sz_reg;
    logic [31:0]   sz_next;
    logic [LW-1:0] lv_reg;
    logic [LW-1:0] lv_next;
    logic          fl_reg;
    logic          fl_next;

    logic          vfound_reg;
    logic          vfound_next;
    logic [SW-1:0] vidx_reg;
    logic [SW-1:0] vidx_next;
    logic [2:0]    walk_reg;          // segment the candidate has reached
    logic [2:0]    walk_next;

    logic          res_v_reg;
    logic          res_v_next;
    logic          res_ev_reg;
    logic          res_ev_next;
    logic [4:0]    res_slot_reg;
    logic [4:0]    res_slot_next;
    logic          res_fl_reg;
    logic          res_fl_next;
    logic [2:0]    res_st_reg;
    logic [2:0]    res_st_next;
    logic          res_av_reg;
    logic          res_av_next;
    logic          res_last_reg;
    logic          res_last_next;

    // cell chain signals: c_* leave a cell, l_* enter one
    logic          c_found [SLOTS+1];
    logic [LW-1:0] c_level [SLOTS+1];
    logic [31:0]   c_stamp [SLOTS+1];
    logic [SW-1:0] c_idx   [SLOTS+1];
    logic          l_found [SLOTS];
    logic [LW-1:0] l_level [SLOTS];
    logic [31:0]   l_stamp [SLOTS];
    logic [SW-1:0] l_idx   [SLOTS];
    logic          cv   [SLOTS];
    logic [31:0]   csz  [SLOTS];
    logic          cfl  [SLOTS];
    logic [LW-1:0] clv  [SLOTS];
    logic [SLOTS-1:0] sel;
    cell_cmd_t     cmd;
    logic [SW-1:0] tgt;

    logic [31:0]   free_b;
    logic          slot_ok;
    logic          hit;
    logic [LW-1:0] lv_in;

    assign c_found[0] = 1'b0;
    assign c_level[0] = '0;
    assign c_stamp[0] = '0;
    assign c_idx[0]   = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        if (g != 0 && (g % GRP) == 0)
        begin : g_link
            // registered hand-off between segments
            logic          found_reg;
            logic [LW-1:0] level_reg;
            logic [31:0]   stamp_reg;
            logic [SW-1:0] idx_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    found_reg <= 1'b0;
                    level_reg <= '0;
                    stamp_reg <= '0;
                    idx_reg   <= '0;
                end
                else
                begin
                    found_reg <= c_found[g];
                    level_reg <= c_level[g];
                    stamp_reg <= c_stamp[g];
                    idx_reg   <= c_idx[g];
                end
            end

            assign l_found[g] = found_reg;
            assign l_level[g] = level_reg;
            assign l_stamp[g] = stamp_reg;
            assign l_idx[g]   = idx_reg;
        end
        else
        begin : g_thru
            assign l_found[g] = c_found[g];
            assign l_level[g] = c_level[g];
            assign l_stamp[g] = c_stamp[g];
            assign l_idx[g]   = c_idx[g];
        end

        llbc_cell #(.LW(LW), .SW(SW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .sel       (sel[g]),
            .cmd       (cmd),
            .min_level (lv_reg),
            .in_found  (l_found[g]),
            .in_level  (l_level[g]),
            .in_stamp  (l_stamp[g]),
            .in_idx    (l_idx[g]),
            .my_idx    (SW'(g)),
            .out_found (c_found[g+1]),
            .out_level (c_level[g+1]),
            .out_stamp (c_stamp[g+1]),
            .out_idx   (c_idx[g+1]),
            .valid     (cv[g]),
            .size      (csz[g]),
            .flush     (cfl[g]),
            .level     (clv[g])
        );
    end

    // level clamp on input
    always_comb
    begin
        if (int'(prio_level) >= LEVELS)
            lv_in = LW'(LEVELS - 1);
        else
            lv_in = LW'(prio_level);
    end

    // free bytes, floored at zero
    always_comb
    begin
        if ({5'd0, cap_reg} > held_full_reg)
            free_b = 32'({5'd0, cap_reg} - held_full_reg);
        else
            free_b = '0;
    end

    assign slot_ok = (int'(s_reg) < SLOTS);
    assign hit     = slot_ok && cv[s_reg[SW-1:0]];

    // command to the cells
    always_comb
    begin
        cmd       = '0;
        cmd.size  = sz_reg;
        cmd.level = 4'(lv_reg);
        cmd.flush = fl_reg;
        cmd.stamp = stamp_reg;
        tgt       = s_reg[SW-1:0];
        sel       = '0;
        if (state_reg == S_EVICT && vfound_reg)
        begin
            cmd.del = 1'b1;
            tgt     = vidx_reg;
            sel[vidx_reg] = 1'b1;
        end
        else if (state_reg == S_EXEC && slot_ok && f_reg == FN_DELETE && hit)
        begin
            cmd.del = 1'b1;
            sel[tgt] = 1'b1;
        end
        else if (state_reg == S_EXEC && slot_ok && f_reg == FN_TOUCH && hit)
        begin
            cmd.touch = 1'b1;
            sel[tgt] = 1'b1;
        end
        else if (state_reg == S_SEARCH && free_b >= sz_reg)
        begin
            cmd.ins = 1'b1;
            sel[tgt] = 1'b1;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // controller next state
    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        thresh_next    = thresh_reg;
        held_full_next = held_full_reg;
        for (int i = 0; i < LEVELS; i++)
            evb_next[i] = evb_reg[i];
        stamp_next     = stamp_reg;
        f_next         = f_reg;
        s_next         = s_reg;
        sz_next        = sz_reg;
        lv_next        = lv_reg;
        fl_next        = fl_reg;
        vfound_next    = vfound_reg;
        vidx_next      = vidx_reg;
        walk_next      = walk_reg;
        res_v_next     = 1'b0;
        res_ev_next    = res_ev_reg;
        res_slot_next  = res_slot_reg;
        res_fl_next    = res_fl_reg;
        res_st_next    = res_st_reg;
        res_av_next    = res_av_reg;
        res_last_next  = res_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == CFG_CAPACITY)
                        cap_next = cfg_data;
                    else
                        thresh_next = cfg_data;
                end
                if (start)
                begin
                    f_next     = func_t'(func);
                    s_next     = slot;
                    sz_next    = entry_size;
                    lv_next    = lv_in;
                    fl_next    = flush_on_evict;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_ev_next   = 1'b0;
                res_slot_next = '0;
                res_fl_next   = 1'b0;
                res_av_next   = 1'b0;
                res_last_next = 1'b1;
                res_st_next   = ST_OK;
                state_next    = S_DONE;
                res_v_next    = 1'b1;
                if (f_reg == FN_QUERY)
                begin
                    res_av_next = ({5'd0, free_b} + evb_reg[lv_reg]) >
                                  {5'd0, thresh_reg};
                end
                else if (!slot_ok)
                    res_st_next = ST_EMPTY;
                else if (f_reg == FN_INSERT)
                begin
                    if (hit)
                        res_st_next = ST_CACHED;
                    else if (sz_reg > cap_reg)
                        res_st_next = ST_LARGE;
                    else
                    begin
                        res_v_next = 1'b0;
                        state_next = S_SEARCH;
                    end
                end
                else if (!hit)
                    res_st_next = ST_EMPTY;
                else if (f_reg == FN_TOUCH)
                    stamp_next = stamp_reg + 32'd1;
                else
                begin
                    held_full_next = held_full_reg - 37'(csz[tgt]);
                    for (int i = 0; i < LEVELS; i++)
                        if (i < int'(clv[tgt]))
                            evb_next[i] = evb_reg[i] - 37'(csz[tgt]);
                end
            end
            S_SEARCH:
            begin
                if (free_b >= sz_reg)
                begin
                    stamp_next     = stamp_reg + 32'd1;
                    held_full_next = held_full_reg + 37'(sz_reg);
                    for (int i = 0; i < LEVELS; i++)
                        if (i < int'(lv_reg))
                            evb_next[i] = evb_reg[i] + 37'(sz_reg);
                    res_v_next    = 1'b1;
                    res_ev_next   = 1'b0;
                    res_slot_next = '0;
                    res_fl_next   = 1'b0;
                    res_st_next   = ST_OK;
                    res_av_next   = 1'b0;
                    res_last_next = 1'b1;
                    state_next    = S_DONE;
                end
                else if (NSEG == 1)
                begin
                    vfound_next = c_found[SLOTS];
                    vidx_next   = c_idx[SLOTS];
                    state_next  = S_EVICT;
                end
                else
                begin
                    // candidate still has to cross the segment links
                    walk_next  = 3'd1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (int'(walk_reg) == NSEG - 1)
                begin
                    vfound_next = c_found[SLOTS];
                    vidx_next   = c_idx[SLOTS];
                    state_next  = S_EVICT;
                end
                else
                    walk_next = walk_reg + 3'd1;
            end
            S_EVICT:
            begin
                res_v_next    = 1'b1;
                res_av_next   = 1'b0;
                if (vfound_reg)
                begin
                    res_ev_next    = 1'b1;
                    res_slot_next  = 5'(vidx_reg);
                    res_fl_next    = cfl[vidx_reg];
                    res_st_next    = ST_OK;
                    res_last_next  = 1'b0;
                    held_full_next = held_full_reg - 37'(csz[vidx_reg]);
                    for (int i = 0; i < LEVELS; i++)
                        if (i < int'(clv[vidx_reg]))
                            evb_next[i] = evb_reg[i] - 37'(csz[vidx_reg]);
                    state_next     = S_SEARCH;
                end
                else
                begin
                    res_ev_next   = 1'b0;
                    res_slot_next = '0;
                    res_fl_next   = 1'b0;
                    res_st_next   = ST_NOVICT;
                    res_last_next = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            thresh_reg    <= THRESH_RESET;
            held_full_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
                evb_reg[i] <= '0;
            stamp_reg     <= '0;
            vfound_reg    <= 1'b0;
            vidx_reg      <= '0;
            walk_reg      <= '0;
            res_v_reg     <= 1'b0;
            res_ev_reg    <= 1'b0;
            res_slot_reg  <= '0;
            res_fl_reg    <= 1'b0;
            res_st_reg    <= '0;
            res_av_reg    <= 1'b0;
            res_last_reg  <= 1'b0;
            f_reg         <= FN_INSERT;
            s_reg         <= '0;
            sz_reg        <= '0;
            lv_reg        <= '0;
            fl_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            thresh_reg    <= thresh_next;
            held_full_reg <= held_full_next;
            for (int i = 0; i < LEVELS; i++)
                evb_reg[i] <= evb_next[i];
            stamp_reg     <= stamp_next;
            vfound_reg    <= vfound_next;
            vidx_reg      <= vidx_next;
            walk_reg      <= walk_next;
            res_v_reg     <= res_v_next;
            res_ev_reg    <= res_ev_next;
            res_slot_reg  <= res_slot_next;
            res_fl_reg    <= res_fl_next;
            res_st_reg    <= res_st_next;
            res_av_reg    <= res_av_next;
            res_last_reg  <= res_last_next;
            f_reg         <= f_next;
            s_reg         <= s_next;
            sz_reg        <= sz_next;
            lv_reg        <= lv_next;
            fl_reg        <= fl_next;
        end
    end

    assign result_strobe = res_v_reg;
    assign is_eviction   = res_ev_reg;
    assign evicted_slot  = res_slot_reg;
    assign evict_flush   = res_fl_reg;
    assign status        = res_st_reg;
    assign available     = res_av_reg;
    assign last          = res_last_reg;

endmodule
